// File: rtl/core/sprite_motion_integrator_assert.svh
// assertion macros shared by the motion integrator modules
`ifndef SPRITE_MOTION_INTEGRATOR_ASSERT_SVH
`define SPRITE_MOTION_INTEGRATOR_ASSERT_SVH

// property must hold on every edge out of reset
`define SMI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication held from reset release
`define SMI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/smi_pkg.sv
package smi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;
    localparam int W         = 32;
    localparam int HW        = 25;

    // register indexes
    localparam logic [2:0] REG_ENABLE      = 3'd0;
    localparam logic [2:0] REG_ACCEL_X     = 3'd1;
    localparam logic [2:0] REG_ACCEL_Y     = 3'd2;
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd3;
    localparam logic [2:0] REG_DRAG        = 3'd4;
    localparam logic [2:0] REG_SPIN_ACCEL  = 3'd5;
    localparam logic [2:0] REG_SPIN_LIMIT  = 3'd6;
    localparam logic [2:0] REG_SPIN_DRAG   = 3'd7;

    // full turn in fixed point
    localparam logic [HW:0] FULL_TURN = (HW+1)'(360 << FRAC_BITS);

    typedef struct packed {
        logic [15:0]         time_step;
        logic                follow_lead;
        logic signed [31:0]  lead_vel_x;
        logic signed [31:0]  lead_vel_y;
        logic                follow_spin;
        logic signed [31:0]  lead_spin;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [HW-1:0]      heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin;
    } t_out;

    // arithmetic unit request and status
    typedef struct packed {
        logic start;
        logic [1:0] op;
    } t_au_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_au_stat;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (v > hi) return 32'sh7FFF_FFFF;
        if (v < lo) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

// File: rtl/core/sprite_motion_integrator.sv
// channel  dir  fields (lsb first)
// cfg      in   i_cfg_index, i_cfg_data
// s_axis   in   tdata: time_step, lead_vel_x, lead_vel_y, lead_spin; tuser: follow_lead, follow_spin
// m_axis   out  tdata: pos_x, pos_y, heading(25, padded), vel_x, vel_y, spin
// a tick with motion disabled goes straight to the output step; otherwise every multiply,
// divide and root holds the one shared bit-serial unit in turn until it is done, and
// the heading wrap then reduces the heading by shifted full turns
// reset is synchronous, clears state to zero and enables motion
// the next word is taken once the previous result has been moved to the output register
module sprite_motion_integrator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,  // time_step, lead_vel_x, lead_vel_y, lead_spin
    input  logic [1:0]    s_axis_tuser,  // follow_lead, follow_spin
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata   // pos_x, pos_y, heading, vel_x, vel_y, spin
);
    import smi_pkg::*;

    // sequencer codes
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SPMUL  = 5'd1;
    localparam logic [4:0] S_SPLIM  = 5'd2;
    localparam logic [4:0] S_SDMUL  = 5'd3;
    localparam logic [4:0] S_HMUL   = 5'd4;
    localparam logic [4:0] S_HWRAP  = 5'd5;
    localparam logic [4:0] S_AXMUL  = 5'd6;
    localparam logic [4:0] S_AYMUL  = 5'd7;
    localparam logic [4:0] S_SQX    = 5'd8;
    localparam logic [4:0] S_SQY    = 5'd9;
    localparam logic [4:0] S_ROOT   = 5'd10;
    localparam logic [4:0] S_LIMCHK = 5'd11;
    localparam logic [4:0] S_CLX    = 5'd12;
    localparam logic [4:0] S_CLXD   = 5'd13;
    localparam logic [4:0] S_CLY    = 5'd14;
    localparam logic [4:0] S_CLYD   = 5'd15;
    localparam logic [4:0] S_DRCHK  = 5'd16;
    localparam logic [4:0] S_DRMUL  = 5'd17;
    localparam logic [4:0] S_DX     = 5'd18;
    localparam logic [4:0] S_DXD    = 5'd19;
    localparam logic [4:0] S_DY     = 5'd20;
    localparam logic [4:0] S_DYD    = 5'd21;
    localparam logic [4:0] S_PXMUL  = 5'd22;
    localparam logic [4:0] S_PYMUL  = 5'd23;
    localparam logic [4:0] S_OUT    = 5'd24;

    // configuration registers
    logic               r_en;
    logic signed [31:0] r_ax, r_ay, r_sacc;
    logic [30:0]        r_slim, r_drag, r_spl, r_sdrag;

    // motion state
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_sp;
    logic [HW-1:0]      r_hd;

    t_in                r_in;
    logic [4:0]         r_st, n_st;
    logic               r_wait;
    logic [63:0]        r_sq, r_len, r_nl;
    logic               r_ovalid;
    logic [191:0]       r_odata;

    t_au_req            au_req;
    t_au_stat           au_stat;
    logic [63:0]        au_a, au_b, au_res;

    logic signed [33:0] prod_s;
    logic [63:0]        mag_sel;
    logic               neg_sel;
    logic signed [33:0] hsum;
    logic [33:0]        r_hacc;
    logic [3:0]         r_hk;
    logic [33:0]        hstep, hrem;
    logic               out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_st == S_IDLE);
    assign out_free      = !r_ovalid || m_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b1; r_ax <= '0; r_ay <= '0; r_sacc <= '0;
            r_slim <= '0; r_drag <= '0; r_spl <= '0; r_sdrag <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENABLE:      r_en    <= i_cfg_data[0];
                REG_ACCEL_X:     r_ax    <= i_cfg_data;
                REG_ACCEL_Y:     r_ay    <= i_cfg_data;
                REG_SPEED_LIMIT: r_slim  <= i_cfg_data[30:0];
                REG_DRAG:        r_drag  <= i_cfg_data[30:0];
                REG_SPIN_ACCEL:  r_sacc  <= i_cfg_data;
                REG_SPIN_LIMIT:  r_spl   <= i_cfg_data[30:0];
                REG_SPIN_DRAG:   r_sdrag <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // operand sign and magnitude for the multiply steps
    always_comb begin
        neg_sel = 1'b0;
        mag_sel = '0;
        case (r_st)
            S_SPMUL: begin neg_sel = r_sacc[31]; mag_sel = 64'(r_sacc[31] ? -35'(r_sacc) : 35'(r_sacc)); end
            S_SDMUL:  mag_sel = 64'(r_sdrag);
            S_HMUL:  begin neg_sel = r_sp[31]; mag_sel = 64'(r_sp[31] ? -35'(r_sp) : 35'(r_sp)); end
            S_AXMUL: begin neg_sel = r_ax[31]; mag_sel = 64'(r_ax[31] ? -35'(r_ax) : 35'(r_ax)); end
            S_AYMUL: begin neg_sel = r_ay[31]; mag_sel = 64'(r_ay[31] ? -35'(r_ay) : 35'(r_ay)); end
            S_DRMUL:  mag_sel = 64'(r_drag);
            S_PXMUL: begin neg_sel = r_vx[31]; mag_sel = 64'(r_vx[31] ? -35'(r_vx) : 35'(r_vx)); end
            S_PYMUL: begin neg_sel = r_vy[31]; mag_sel = 64'(r_vy[31] ? -35'(r_vy) : 35'(r_vy)); end
            S_SQX:    mag_sel = 64'(r_vx[31] ? -35'(r_vx) : 35'(r_vx));
            S_SQY:    mag_sel = 64'(r_vy[31] ? -35'(r_vy) : 35'(r_vy));
            S_CLX, S_DX: mag_sel = 64'(r_vx[31] ? -35'(r_vx) : 35'(r_vx));
            S_CLY, S_DY: mag_sel = 64'(r_vy[31] ? -35'(r_vy) : 35'(r_vy));
            default: ;
        endcase
    end

    // signed rate times dt from the unit result
    assign prod_s = neg_sel ? -34'($signed({1'b0, au_res[48:DT_BITS]}))
                            : 34'($signed({1'b0, au_res[48:DT_BITS]}));

    // unit request
    always_comb begin
        au_req.start = !r_wait;
        au_req.op    = OP_MUL;
        au_a = mag_sel;
        au_b = 64'(r_in.time_step);
        case (r_st)
            S_SQX, S_SQY: au_b = mag_sel;
            S_ROOT: begin au_req.op = OP_SQRT; au_a = r_sq; end
            S_CLX, S_CLY: au_b = 64'(r_slim);
            S_DX, S_DY: au_b = r_nl;
            S_CLXD, S_CLYD, S_DXD, S_DYD: begin
                au_req.op = OP_DIV; au_a = r_sq; au_b = r_len;
            end
            S_SPMUL, S_SDMUL, S_HMUL, S_AXMUL, S_AYMUL, S_DRMUL,
            S_PXMUL, S_PYMUL: ;
            default: au_req.start = 1'b0;
        endcase
    end

    smi_serial_unit u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (au_req),
        .i_a    (au_a),
        .i_b    (au_b),
        .o_stat (au_stat),
        .o_res  (au_res)
    );

    // heading sum, then reduced by shifted full turns one step a cycle
    assign hsum  = 34'(r_hd) + prod_s;
    assign hstep = 34'(FULL_TURN) << r_hk;
    assign hrem  = (r_hacc >= hstep) ? r_hacc - hstep : r_hacc;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_wait <= 1'b0; r_ovalid <= 1'b0;
            r_px <= '0; r_py <= '0; r_vx <= '0; r_vy <= '0; r_sp <= '0; r_hd <= '0;
        end else begin
            if (r_st == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (au_req.start) r_wait <= 1'b1;
            if (au_stat.done) r_wait <= 1'b0;
            r_st <= n_st;
            case (r_st)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_in <= {s_axis_tdata[15:0], s_axis_tuser[0], s_axis_tdata[47:16],
                             s_axis_tdata[79:48], s_axis_tuser[1], s_axis_tdata[111:80]};
                end
                S_SPMUL: if (au_stat.done) r_sp <= sat32(34'(r_sp) + prod_s);
                S_SPLIM: if (r_spl != 0) begin
                    if (r_sp > $signed({1'b0, r_spl})) r_sp <= {1'b0, r_spl};
                    else if (r_sp < -$signed({1'b0, r_spl})) r_sp <= -$signed({1'b0, r_spl});
                end
                S_SDMUL: if (au_stat.done) begin
                    if (34'(au_res[48:DT_BITS]) >= 34'(r_sp[31] ? -35'(r_sp) : 35'(r_sp)))
                        r_sp <= '0;
                    else if (r_sp[31]) r_sp <= r_sp + 32'(au_res[48:DT_BITS]);
                    else r_sp <= r_sp - 32'(au_res[48:DT_BITS]);
                end
                // offset by 128 full turns so the sum is never negative
                S_HMUL: if (au_stat.done) begin
                    r_hacc <= 34'(hsum) + (34'(FULL_TURN) << 7);
                    r_hk   <= 4'd8;
                end
                S_HWRAP: begin
                    r_hacc <= hrem;
                    r_hk   <= r_hk - 4'd1;
                    if (r_hk == 4'd0) r_hd <= HW'(hrem);
                end
                S_AXMUL: if (au_stat.done) r_vx <= sat32(34'(r_vx) + prod_s);
                S_AYMUL: if (au_stat.done) r_vy <= sat32(34'(r_vy) + prod_s);
                S_SQX: if (au_stat.done) r_sq <= au_res;
                S_SQY: if (au_stat.done) r_sq <= r_sq + au_res;
                S_ROOT: if (au_stat.done) r_len <= au_res;
                S_CLX, S_CLY, S_DX, S_DY: if (au_stat.done) r_sq <= au_res;
                S_CLXD, S_DXD: if (au_stat.done)
                    r_vx <= sat32(r_vx[31] ? -34'(au_res[32:0]) : 34'(au_res[32:0]));
                S_CLYD, S_DYD: if (au_stat.done) begin
                    r_vy <= sat32(r_vy[31] ? -34'(au_res[32:0]) : 34'(au_res[32:0]));
                    if (r_st == S_CLYD) r_len <= 64'(r_slim);
                end
                S_DRMUL: if (au_stat.done)
                    r_nl <= (au_res[48:DT_BITS] >= r_len[32:0]) ? '0
                          : r_len - 64'(au_res[48:DT_BITS]);
                S_PXMUL: if (au_stat.done) r_px <= sat32(34'(r_px) + prod_s);
                S_PYMUL: if (au_stat.done) r_py <= sat32(34'(r_py) + prod_s);
                S_OUT: if (out_free) begin
                    r_odata  <= {r_sp, r_vy, r_vx, 7'd0, r_hd, r_py, r_px};
                end
                default: ;
            endcase
            // leader copies
            if (r_st == S_IDLE && n_st == S_HMUL && s_axis_tuser[1])
                r_sp <= s_axis_tdata[111:80];
            if (r_st == S_HMUL && au_stat.done && r_in.follow_lead) begin
                r_vx <= r_in.lead_vel_x; r_vy <= r_in.lead_vel_y;
            end
        end
    end

    // next step
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (s_axis_tvalid && s_axis_tready)
                n_st = !r_en ? S_OUT : (s_axis_tuser[1] ? S_HMUL : S_SPMUL);
            S_SPMUL: if (au_stat.done) n_st = S_SPLIM;
            S_SPLIM: n_st = (r_sdrag != 0 && r_sacc == 0 && r_sp != 0) ? S_SDMUL : S_HMUL;
            S_SDMUL: if (au_stat.done) n_st = S_HMUL;
            S_HMUL: if (au_stat.done) n_st = S_HWRAP;
            S_HWRAP: if (r_hk == 4'd0) n_st = r_in.follow_lead ? S_PXMUL : S_AXMUL;
            S_AXMUL: if (au_stat.done) n_st = S_AYMUL;
            S_AYMUL: if (au_stat.done) n_st = S_SQX;
            S_SQX: if (au_stat.done) n_st = S_SQY;
            S_SQY: if (au_stat.done) n_st = S_ROOT;
            S_ROOT: if (au_stat.done) n_st = S_LIMCHK;
            S_LIMCHK: n_st = (r_slim != 0 && r_len > 64'(r_slim)) ? S_CLX : S_DRCHK;
            S_CLX: if (au_stat.done) n_st = S_CLXD;
            S_CLXD: if (au_stat.done) n_st = S_CLY;
            S_CLY: if (au_stat.done) n_st = S_CLYD;
            S_CLYD: if (au_stat.done) n_st = S_DRCHK;
            S_DRCHK: n_st = (r_drag != 0 && r_len != 0 && r_ax == 0 && r_ay == 0)
                            ? S_DRMUL : S_PXMUL;
            S_DRMUL: if (au_stat.done) n_st = S_DX;
            S_DX: if (au_stat.done) n_st = S_DXD;
            S_DXD: if (au_stat.done) n_st = S_DY;
            S_DY: if (au_stat.done) n_st = S_DYD;
            S_DYD: if (au_stat.done) n_st = S_PXMUL;
            S_PXMUL: if (au_stat.done) n_st = S_PYMUL;
            S_PYMUL: if (au_stat.done) n_st = S_OUT;
            S_OUT: if (out_free) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `include "sprite_motion_integrator_assert.svh"
    `SMI_ASSERT(a_hd_range, i_clk, i_rst_n, 26'(r_hd) < 26'(FULL_TURN), "heading out of range")
    `SMI_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, s_axis_tready, r_st == S_IDLE, "accept while busy")
    `SMI_ASSERT_IMP(a_out_from_seq, i_clk, i_rst_n, $rose(r_ovalid), $past(r_st) == S_OUT, "stray result")
endmodule

// File: rtl/core/smi_serial_unit.sv
// bit-serial multiply, divide and square root, one bit per cycle
module smi_serial_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  smi_pkg::t_au_req i_req,
    input  logic [63:0]     i_a,
    input  logic [63:0]     i_b,
    output smi_pkg::t_au_stat o_stat,
    output logic [63:0]     o_res
);
    import smi_pkg::*;

    logic [63:0]  r_acc, n_acc;
    logic [63:0]  r_a, n_a;
    logic [63:0]  r_b, n_b;
    logic [63:0]  r_rem, n_rem;
    logic [6:0]   r_cnt, n_cnt;
    logic [1:0]   r_op, n_op;
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [64:0]  trial;
    logic [65:0]  strial;
    logic [65:0]  sroot;

    // one step of the selected operation
    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = '0;
        sroot  = '0;
        strial = '0;
        if (i_req.start && !r_busy) begin
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
            n_rem  = '0;
            n_op   = i_req.op;
            n_busy = 1'b1;
            n_cnt  = (i_req.op == OP_SQRT) ? 7'd32 : 7'd64;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    // shift-add, multiplier consumed lsb first
                    if (r_b[0]) n_acc = r_acc + r_a;
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                end
                OP_DIV: begin
                    // restoring division, dividend msb first
                    trial = {r_rem, r_a[63]};
                    n_a   = r_a << 1;
                    if (trial >= {1'b0, r_b}) begin
                        n_rem = 64'(trial - {1'b0, r_b});
                        n_acc = {r_acc[62:0], 1'b1};
                    end else begin
                        n_rem = trial[63:0];
                        n_acc = {r_acc[62:0], 1'b0};
                    end
                end
                OP_SQRT: begin
                    // two radicand bits per step
                    sroot  = {r_rem, r_a[63:62]};
                    strial = {r_acc, 2'b01};
                    n_a    = r_a << 2;
                    if (sroot >= strial) begin
                        n_rem = 64'(sroot - strial);
                        n_acc = {r_acc[62:0], 1'b1};
                    end else begin
                        n_rem = sroot[63:0];
                        n_acc = {r_acc[62:0], 1'b0};
                    end
                end
                default: n_busy = 1'b0;
            endcase
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_rem <= n_rem;
        r_op  <= n_op;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_acc;

    `include "sprite_motion_integrator_assert.svh"
    `SMI_ASSERT_IMP(a_done_after_busy, i_clk, i_rst_n, r_done, !$past(r_done), "done held")
    `SMI_ASSERT_IMP(a_cnt_busy, i_clk, i_rst_n, r_busy, r_cnt != 7'd0, "busy with zero count")
    `SMI_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "done while busy")
endmodule
